### hdl/sdrm_pkg.sv
// Package for the signed divider with rounding modes.
// Holds rounding mode and status codes and the per-stage record type.
// No dependencies.
package sdrm_pkg;

    typedef enum logic [2:0] {
        MODE_TRUNC = 3'd0,
        MODE_FLOOR = 3'd1,
        MODE_CEIL  = 3'd2,
        MODE_HALF  = 3'd3,
        MODE_EUCL  = 3'd4
    } mode_t;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_DIV0 = 2'd1;
    localparam logic [1:0] STAT_OVF  = 2'd2;

    // control flags carried alongside each operation through the chain
    typedef struct packed {
        logic       valid;
        logic [2:0] mode;
        logic       a_neg;
        logic       b_neg;
        logic [1:0] status;
    } sdrm_ctl_t;

endpackage

### hdl/sdrm_cell.sv
// One restoring-division cell: retires one quotient bit per cycle while en is high.
// Depends on sdrm_pkg.
module sdrm_cell #(
    parameter int WIDTH = 64,
    parameter int BIT   = 0
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  sdrm_pkg::sdrm_ctl_t        ctl_in,
    input  logic [WIDTH-1:0]           rem_in,
    input  logic [WIDTH-1:0]           quo_in,
    input  logic [WIDTH-1:0]           div_in,
    output sdrm_pkg::sdrm_ctl_t        ctl_out,
    output logic [WIDTH-1:0]           rem_out,
    output logic [WIDTH-1:0]           quo_out,
    output logic [WIDTH-1:0]           div_out
);
    import sdrm_pkg::*;

    sdrm_ctl_t        ctl_reg;
    logic [WIDTH-1:0] rem_reg, quo_reg, div_reg;
    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic             fits;
    logic [WIDTH-1:0] quo_next;

    // shift in next dividend bit (quo_in holds unprocessed dividend bits)
    assign trial = {rem_in, quo_in[BIT]};
    assign diff  = trial - {1'b0, div_in};
    assign fits  = !diff[WIDTH];

    always_comb begin
        quo_next      = quo_in;
        quo_next[BIT] = fits;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
        if (en) begin
            rem_reg <= fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            quo_reg <= quo_next;
            div_reg <= div_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign quo_out = quo_reg;
    assign div_out = div_reg;
endmodule

### hdl/sdrm_round.sv
// Final stage: applies rounding mode, sign, remainder correction and the divide-by-zero and overflow results.
// Depends on sdrm_pkg.
module sdrm_round #(
    parameter int WIDTH = 64
) (
    input  sdrm_pkg::sdrm_ctl_t ctl,
    input  logic [WIDTH-1:0]    mq,
    input  logic [WIDTH-1:0]    mr,
    input  logic [WIDTH-1:0]    ub,
    output logic [WIDTH-1:0]    q,
    output logic [WIDTH-1:0]    r
);
    import sdrm_pkg::*;

    logic       neg, inexact, away, half;
    logic [2:0] m;
    logic [WIDTH-1:0] mq1;

    always_comb begin
        neg     = ctl.a_neg ^ ctl.b_neg;
        inexact = mr != '0;
        half    = mr >= (ub - mr);
        m       = ctl.mode;
        if (m == MODE_EUCL) m = ctl.b_neg ? MODE_CEIL : MODE_FLOOR;
        case (m)
            MODE_FLOOR: away = inexact && neg;
            MODE_CEIL:  away = inexact && !neg;
            MODE_HALF:  away = inexact && half;
            default:    away = 1'b0;
        endcase
        mq1 = mq + WIDTH'(away);
        q   = neg ? '0 - mq1 : mq1;
        // remainder adjusts by a divisor-magnitude step when rounding away
        if (!away) r = ctl.a_neg ? '0 - mr : mr;
        else       r = ctl.a_neg ? ub - mr : mr - ub;
        if (ctl.status == STAT_DIV0) begin
            q = '0;
            r = '0;
        end else if (ctl.status == STAT_OVF) begin
            q = {1'b1, {(WIDTH-1){1'b0}}};
            r = '0;
        end
    end
endmodule

### hdl/signed_divider_rounding_modes.sv
// Signed divider, five rounding modes, 64-bit operands on 128-bit stream ports.
// Pipeline from input transfer to output valid: input register, WIDTH division cells,
// output register.
// Throughput: one transfer per cycle; the whole chain advances when the output slot frees.
// Reset: synchronous active-low aresetn clears all valid flags; data is not reset.
// Depends on sdrm_pkg, sdrm_cell, sdrm_round.
module signed_divider_rounding_modes #(
    parameter int WIDTH = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // dividend[63:0], divisor[127:64]
    input  logic [2:0]   s_tuser,   // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // quotient[63:0], remainder[127:64]
    output logic [1:0]   m_tuser    // status
);
    import sdrm_pkg::*;

    localparam int N = WIDTH;

    logic             adv;
    sdrm_ctl_t        ctl   [0:N];
    logic [WIDTH-1:0] rem   [0:N];
    logic [WIDTH-1:0] quo   [0:N];
    logic [WIDTH-1:0] dv    [0:N];

    logic [WIDTH-1:0] a_in, b_in, ua, ub;
    logic             div0, ovf;
    sdrm_ctl_t        ctl_reg;
    logic [WIDTH-1:0] ua_reg, ub_reg;
    logic             out_valid_reg;
    logic [63:0]      q_reg, r_reg;
    logic [1:0]       st_reg;
    logic [WIDTH-1:0] q_fin, r_fin;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    assign a_in = s_tdata[WIDTH-1:0];
    assign b_in = s_tdata[64+WIDTH-1:64];
    assign ua   = a_in[WIDTH-1] ? '0 - a_in : a_in;
    assign ub   = b_in[WIDTH-1] ? '0 - b_in : b_in;
    assign div0 = b_in == '0;
    assign ovf  = a_in == {1'b1, {(WIDTH-1){1'b0}}} && b_in == '1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (adv) begin
            ctl_reg.valid  <= s_tvalid;
            ctl_reg.mode   <= s_tuser;
            ctl_reg.a_neg  <= a_in[WIDTH-1];
            ctl_reg.b_neg  <= b_in[WIDTH-1];
            ctl_reg.status <= div0 ? STAT_DIV0 : (ovf ? STAT_OVF : STAT_OK);
        end
        if (adv) begin
            ua_reg <= ua;
            ub_reg <= div0 ? {{(WIDTH-1){1'b0}}, 1'b1} : ub;
        end
    end

    assign ctl[0] = ctl_reg;
    assign rem[0] = '0;
    assign quo[0] = ua_reg;
    assign dv[0]  = ub_reg;

    for (genvar i = 0; i < N; i++) begin : g_cell
        sdrm_cell #(.WIDTH(WIDTH), .BIT(N-1-i)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .ctl_in  (ctl[i]),
            .rem_in  (rem[i]),
            .quo_in  (quo[i]),
            .div_in  (dv[i]),
            .ctl_out (ctl[i+1]),
            .rem_out (rem[i+1]),
            .quo_out (quo[i+1]),
            .div_out (dv[i+1])
        );
    end

    sdrm_round #(.WIDTH(WIDTH)) u_round (
        .ctl (ctl[N]),
        .mq  (quo[N]),
        .mr  (rem[N]),
        .ub  (dv[N]),
        .q   (q_fin),
        .r   (r_fin)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= ctl[N].valid;
        end
        if (adv) begin
            q_reg  <= 64'(signed'(q_fin));
            r_reg  <= 64'(signed'(r_fin));
            st_reg <= ctl[N].status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {r_reg, q_reg};
    assign m_tuser  = st_reg;
endmodule
